/* rtl/core/spfl_pkg.sv */
package spfl_pkg;

    // Slot pool geometry
    localparam int SLOT_COUNT = 256;
    localparam int IDX_W      = 8;
    localparam int SLOT_W     = 9;
    localparam int DATA_W     = 64;

    // Slot reference that means "no slot"
    localparam logic [SLOT_W-1:0] NO_SLOT = '1;

    typedef enum logic [2:0] {
        OP_ACQUIRE = 3'd0,
        OP_RELEASE = 3'd1,
        OP_ACTIVE  = 3'd2,
        OP_SET     = 3'd3,
        OP_GET     = 3'd4,
        OP_FIRST   = 3'd5,
        OP_NEXT    = 3'd6,
        OP_CLEAR   = 3'd7
    } t_opcode;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EXEC = 6'b000100,
        S_SCAN = 6'b001000,
        S_SCHK = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

endpackage

/* rtl/core/slot_pool_free_list_allocator.sv */
// Slot pool with a LIFO free list and a linked list of active slots.
// Input channel: opcode, slot index and write value are taken at a rising
// edge with i_start high and o_busy low. Each item gives one result, shown on
// the o_ result ports for one cycle with o_valid high; the receiver cannot
// stall, so the result is simply dropped after that cycle.
// An item passes through S_READ, S_EXEC and S_RESP; o_valid rises in the same
// cycle as o_busy falls, so a new item is taken only after the last result.
// Release of a slot that is not at the head of the active list walks the
// list through the single read port of the link memory, passing through
// S_SCAN and S_SCHK for each node from the head up to and including the
// predecessor.
// Configuration: i_cfg_we writes the capacity (clamped to 1..256) and
// reinitializes the pool, as does the clear opcode.
// Reset: capacity 256, all slots free, no active slot. Free slots never yet
// handed out are tracked by a fill count, and active flags are flip-flops,
// so no clearing pass over the memories is needed.
module slot_pool_free_list_allocator
    import spfl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [2:0]               i_opcode,
    input  logic [IDX_W-1:0]         i_slot_index,
    input  logic signed [DATA_W-1:0] i_write_value,
    input  logic                     i_cfg_we,
    input  logic [SLOT_W-1:0]        i_cfg_wdata,
    output logic                     o_valid,
    output logic                     o_success,
    output logic signed [SLOT_W-1:0] o_slot_result,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [SLOT_W-1:0]        o_used_count,
    output logic [SLOT_W-1:0]        o_available_count,
    output logic                     o_pool_full,
    output logic                     o_pool_empty
);

    // Memories
    logic [DATA_W-1:0] mem_data  [SLOT_COUNT];
    logic [SLOT_W-1:0] mem_alink [SLOT_COUNT];
    logic [SLOT_W-1:0] mem_flink [SLOT_COUNT];

    logic              dm_we, al_we, fl_we;
    logic [IDX_W-1:0]  dm_wa, al_wa, fl_wa, al_ra;
    logic [DATA_W-1:0] dm_wd, dm_q;
    logic [SLOT_W-1:0] al_wd, fl_wd, al_q, fl_q;

    // Control and bookkeeping state
    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [DATA_W-1:0] r_wv, n_wv;
    logic [SLOT_W-1:0] r_cap, n_cap;
    logic [SLOT_W-1:0] r_count, n_count;
    logic [SLOT_W-1:0] r_fill, n_fill;
    logic [SLOT_W-1:0] r_fhead, n_fhead;
    logic [SLOT_W-1:0] r_ahead, n_ahead;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_link_s, n_link_s;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    logic              r_ok, n_ok;
    logic [SLOT_W-1:0] r_res, n_res;
    logic [DATA_W-1:0] r_rd, n_rd;

    logic              slot_valid;
    logic [SLOT_W-1:0] idx_ext;
    logic [SLOT_W-1:0] h_next;
    logic [SLOT_W-1:0] cfg_cap;

    assign idx_ext    = {1'b0, r_idx};
    assign slot_valid = (idx_ext < r_cap) && r_in_use[r_idx];
    assign h_next     = (r_fhead + 1'b1 < r_cap) ? r_fhead + 1'b1 : NO_SLOT;
    assign cfg_cap    = (i_cfg_wdata == '0) ? SLOT_W'(1) :
                        ((i_cfg_wdata > SLOT_W'(SLOT_COUNT)) ? SLOT_W'(SLOT_COUNT)
                                                             : i_cfg_wdata);
    assign al_ra      = (r_state == S_SCAN) ? r_cur[IDX_W-1:0] : r_idx;
    assign o_busy     = (r_state != S_IDLE);

    // Memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            mem_data[dm_wa] <= dm_wd;
        end
        dm_q <= mem_data[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (al_we) begin
            mem_alink[al_wa] <= al_wd;
        end
        al_q <= mem_alink[al_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            mem_flink[fl_wa] <= fl_wd;
        end
        fl_q <= mem_flink[r_fhead[IDX_W-1:0]];
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_idx    = r_idx;
        n_wv     = r_wv;
        n_cap    = r_cap;
        n_count  = r_count;
        n_fill   = r_fill;
        n_fhead  = r_fhead;
        n_ahead  = r_ahead;
        n_cur    = r_cur;
        n_link_s = r_link_s;
        n_in_use = r_in_use;
        n_ok     = r_ok;
        n_res    = r_res;
        n_rd     = r_rd;
        dm_we = 1'b0; dm_wa = r_idx;            dm_wd = r_wv;
        al_we = 1'b0; al_wa = r_fhead[IDX_W-1:0]; al_wd = r_ahead;
        fl_we = 1'b0; fl_wa = r_idx;            fl_wd = r_fhead;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_idx   = i_slot_index;
                    n_wv    = i_write_value;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_ok    = 1'b0;
                n_res   = NO_SLOT;
                n_rd    = '0;
                n_state = S_RESP;
                case (r_op)
                    OP_ACQUIRE: begin
                        if (!r_fhead[SLOT_W-1]) begin
                            // pop free list, prepend to active list
                            if (r_fhead >= r_fill) begin
                                n_fhead = h_next;
                                n_fill  = r_fhead + 1'b1;
                            end else begin
                                n_fhead = fl_q;
                            end
                            al_we   = 1'b1;
                            dm_we   = 1'b1;
                            dm_wa   = r_fhead[IDX_W-1:0];
                            dm_wd   = '0;
                            n_in_use[r_fhead[IDX_W-1:0]] = 1'b1;
                            n_ahead = r_fhead;
                            n_count = r_count + 1'b1;
                            n_ok    = 1'b1;
                            n_res   = r_fhead;
                        end
                    end
                    OP_RELEASE: begin
                        if (slot_valid) begin
                            n_ok    = 1'b1;
                            n_in_use[r_idx] = 1'b0;
                            fl_we   = 1'b1;
                            n_fhead = idx_ext;
                            n_count = r_count - 1'b1;
                            if (r_ahead == idx_ext) begin
                                n_ahead = al_q;
                            end else begin
                                // walk the list for the predecessor
                                n_link_s = al_q;
                                n_cur    = r_ahead;
                                n_state  = S_SCAN;
                            end
                        end
                    end
                    OP_ACTIVE: begin
                        n_ok = slot_valid;
                    end
                    OP_SET: begin
                        if (slot_valid) begin
                            dm_we = 1'b1;
                            n_ok  = 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (slot_valid) begin
                            n_rd = dm_q;
                            n_ok = 1'b1;
                        end
                    end
                    OP_FIRST: begin
                        n_res = r_ahead;
                        n_ok  = !r_ahead[SLOT_W-1];
                    end
                    OP_NEXT: begin
                        if (slot_valid) begin
                            n_res = al_q;
                            n_ok  = !al_q[SLOT_W-1];
                        end
                    end
                    default: begin
                        n_in_use = '0;
                        n_fhead  = '0;
                        n_ahead  = NO_SLOT;
                        n_count  = '0;
                        n_fill   = '0;
                        n_ok     = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (al_q == idx_ext) begin
                    // unlink the released slot
                    al_we   = 1'b1;
                    al_wa   = r_cur[IDX_W-1:0];
                    al_wd   = r_link_s;
                    n_state = S_RESP;
                end else begin
                    n_cur   = al_q;
                    n_state = S_SCAN;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capacity write reinitializes the pool
        if (i_cfg_we) begin
            n_cap    = cfg_cap;
            n_in_use = '0;
            n_fhead  = '0;
            n_ahead  = NO_SLOT;
            n_count  = '0;
            n_fill   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= SLOT_W'(SLOT_COUNT);
            r_count  <= '0;
            r_fill   <= '0;
            r_fhead  <= '0;
            r_ahead  <= NO_SLOT;
            r_in_use <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_fhead  <= n_fhead;
            r_ahead  <= n_ahead;
            r_in_use <= n_in_use;
            o_valid  <= (r_state == S_RESP);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_wv     <= n_wv;
        r_cur    <= n_cur;
        r_link_s <= n_link_s;
        r_ok     <= n_ok;
        r_res    <= n_res;
        r_rd     <= n_rd;
        if (r_state == S_RESP) begin
            o_success         <= r_ok;
            o_slot_result     <= r_res;
            o_read_value      <= r_rd;
            o_used_count      <= r_count;
            o_available_count <= r_cap - r_count;
            o_pool_full       <= (r_count >= r_cap);
            o_pool_empty      <= (r_count == '0);
        end
    end

endmodule
